/* src/hsv2rgb_pkg.sv */
package hsv2rgb_pkg;

    typedef enum logic {
        MODEL_HSV = 1'b0,
        MODEL_HSL = 1'b1
    } color_model_t;

    typedef enum logic [2:0] {
        SECTOR_0 = 3'd0,
        SECTOR_1 = 3'd1,
        SECTOR_2 = 3'd2,
        SECTOR_3 = 3'd3,
        SECTOR_4 = 3'd4,
        SECTOR_5 = 3'd5
    } sector_t;

    localparam int SECTOR_BITS = 3;

    // control that travels with each word through the pipe
    typedef struct packed {
        logic         valid;
        color_model_t model;
        sector_t      sector;
    } stage_ctl_t;

endpackage

/* src/hsv_hsl_to_rgb_unit.sv */
// Channel  Dir  Handshake          Payload
// s_       in   s_valid/s_ready    s_hue, s_saturation, s_brightness, s_alpha_in
// m_       out  m_valid/m_ready    m_red, m_green, m_blue, m_alpha_out
// cfg_     in   cfg_valid/cfg_ready cfg_data (color model, 0 = HSV, 1 = HSL)
//
// Four register stages: hue sector and chroma base, chroma multiply,
// second channel multiply and offset, channel select and add.
// One word per cycle sustained while m_ready is high.
// Each stage holds its word while the next one is full and stalled; bubbles close up.
// Synchronous active-low reset empties the pipe and sets the model to HSV.
module hsv_hsl_to_rgb_unit #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic                    cfg_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  logic [CHANNEL_BITS-1:0] s_hue,
    input  logic [CHANNEL_BITS-1:0] s_saturation,
    input  logic [CHANNEL_BITS-1:0] s_brightness,
    input  logic [CHANNEL_BITS-1:0] s_alpha_in,
    output logic                    m_valid,
    input  logic                    m_ready,
    output logic [CHANNEL_BITS-1:0] m_red,
    output logic [CHANNEL_BITS-1:0] m_green,
    output logic [CHANNEL_BITS-1:0] m_blue,
    output logic [CHANNEL_BITS-1:0] m_alpha_out
);

    localparam int N = CHANNEL_BITS;

    hsv2rgb_pkg::color_model_t model_reg, model_next;

    hsv2rgb_pkg::stage_ctl_t ctl1, ctl2, ctl3;
    logic         rdy2, rdy3, rdy4;
    logic [N:0]   k1;
    logic [N-1:0] f1, sat1, bri1, alpha1;
    logic [N-1:0] c2, bri2, alpha2;
    logic [N:0]   fe2;
    logic [N-1:0] c3, x3, m3, alpha3;

    assign cfg_ready = 1'b1;

    always_comb begin
        model_next = model_reg;
        if (cfg_valid && cfg_ready) begin
            model_next = hsv2rgb_pkg::color_model_t'(cfg_data);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            model_reg <= hsv2rgb_pkg::MODEL_HSV;
        end else begin
            model_reg <= model_next;
        end
    end

    hsv2rgb_prep #(.CHANNEL_BITS(N)) u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_model  (model_reg),
        .in_hue    (s_hue),
        .in_sat    (s_saturation),
        .in_bri    (s_brightness),
        .in_alpha  (s_alpha_in),
        .out_ctl   (ctl1),
        .out_ready (rdy2),
        .out_k     (k1),
        .out_f     (f1),
        .out_sat   (sat1),
        .out_bri   (bri1),
        .out_alpha (alpha1)
    );

    hsv2rgb_chroma #(.CHANNEL_BITS(N)) u_chroma (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (ctl1),
        .in_ready  (rdy2),
        .in_k      (k1),
        .in_f      (f1),
        .in_sat    (sat1),
        .in_bri    (bri1),
        .in_alpha  (alpha1),
        .out_ctl   (ctl2),
        .out_ready (rdy3),
        .out_c     (c2),
        .out_fe    (fe2),
        .out_bri   (bri2),
        .out_alpha (alpha2)
    );

    hsv2rgb_blend #(.CHANNEL_BITS(N)) u_blend (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (ctl2),
        .in_ready  (rdy3),
        .in_c      (c2),
        .in_fe     (fe2),
        .in_bri    (bri2),
        .in_alpha  (alpha2),
        .out_ctl   (ctl3),
        .out_ready (rdy4),
        .out_c     (c3),
        .out_x     (x3),
        .out_m     (m3),
        .out_alpha (alpha3)
    );

    hsv2rgb_mix #(.CHANNEL_BITS(N)) u_mix (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_ctl    (ctl3),
        .in_ready  (rdy4),
        .in_c      (c3),
        .in_x      (x3),
        .in_m      (m3),
        .in_alpha  (alpha3),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_red   (m_red),
        .out_green (m_green),
        .out_blue  (m_blue),
        .out_alpha (m_alpha_out)
    );

endmodule

/* src/hsv2rgb_prep.sv */
module hsv2rgb_prep #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  hsv2rgb_pkg::color_model_t     in_model,
    input  logic [CHANNEL_BITS-1:0]       in_hue,
    input  logic [CHANNEL_BITS-1:0]       in_sat,
    input  logic [CHANNEL_BITS-1:0]       in_bri,
    input  logic [CHANNEL_BITS-1:0]       in_alpha,
    output hsv2rgb_pkg::stage_ctl_t       out_ctl,
    input  logic                          out_ready,
    output logic [CHANNEL_BITS:0]         out_k,
    output logic [CHANNEL_BITS-1:0]       out_f,
    output logic [CHANNEL_BITS-1:0]       out_sat,
    output logic [CHANNEL_BITS-1:0]       out_bri,
    output logic [CHANNEL_BITS-1:0]       out_alpha
);

    localparam int N = CHANNEL_BITS;
    localparam int PW = N + hsv2rgb_pkg::SECTOR_BITS;

    hsv2rgb_pkg::stage_ctl_t ctl_reg, ctl_next;
    logic [N:0]   k_reg, k_next;
    logic [N-1:0] f_reg, f_next;
    logic [N-1:0] sat_reg, sat_next;
    logic [N-1:0] bri_reg, bri_next;
    logic [N-1:0] alpha_reg, alpha_next;
    logic [PW-1:0] hue6;

    assign in_ready = !ctl_reg.valid || out_ready;
    // hue * 6 = hue * 4 + hue * 2
    assign hue6 = PW'({in_hue, 2'b00}) + PW'({in_hue, 1'b0});

    always_comb begin
        ctl_next   = ctl_reg;
        k_next     = k_reg;
        f_next     = f_reg;
        sat_next   = sat_reg;
        bri_next   = bri_reg;
        alpha_next = alpha_reg;
        if (in_ready) begin
            ctl_next.valid = in_valid;
        end
        if (in_ready && in_valid) begin
            ctl_next.model  = in_model;
            ctl_next.sector = hsv2rgb_pkg::sector_t'(hue6[PW-1:N]);
            f_next          = hue6[N-1:0];
            sat_next        = in_sat;
            bri_next        = in_bri;
            alpha_next      = in_alpha;
            if (in_model == hsv2rgb_pkg::MODEL_HSV) begin
                k_next = {1'b0, in_bri};
            end else if (!in_bri[N-1]) begin
                k_next = {in_bri, 1'b0};
            end else begin
                k_next = (N+1)'(0) - {in_bri, 1'b0};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_next;
        end
        k_reg     <= k_next;
        f_reg     <= f_next;
        sat_reg   <= sat_next;
        bri_reg   <= bri_next;
        alpha_reg <= alpha_next;
    end

    assign out_ctl   = ctl_reg;
    assign out_k     = k_reg;
    assign out_f     = f_reg;
    assign out_sat   = sat_reg;
    assign out_bri   = bri_reg;
    assign out_alpha = alpha_reg;

endmodule

/* src/hsv2rgb_chroma.sv */
module hsv2rgb_chroma #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hsv2rgb_pkg::stage_ctl_t       in_ctl,
    output logic                          in_ready,
    input  logic [CHANNEL_BITS:0]         in_k,
    input  logic [CHANNEL_BITS-1:0]       in_f,
    input  logic [CHANNEL_BITS-1:0]       in_sat,
    input  logic [CHANNEL_BITS-1:0]       in_bri,
    input  logic [CHANNEL_BITS-1:0]       in_alpha,
    output hsv2rgb_pkg::stage_ctl_t       out_ctl,
    input  logic                          out_ready,
    output logic [CHANNEL_BITS-1:0]       out_c,
    output logic [CHANNEL_BITS:0]         out_fe,
    output logic [CHANNEL_BITS-1:0]       out_bri,
    output logic [CHANNEL_BITS-1:0]       out_alpha
);

    localparam int N = CHANNEL_BITS;

    hsv2rgb_pkg::stage_ctl_t ctl_reg, ctl_next;
    logic [N-1:0] c_reg, c_next;
    logic [N:0]   fe_reg, fe_next;
    logic [N-1:0] bri_reg, bri_next;
    logic [N-1:0] alpha_reg, alpha_next;
    logic [2*N:0] prod;

    assign in_ready = !ctl_reg.valid || out_ready;
    assign prod = (2*N+1)'(in_k) * (2*N+1)'(in_sat);

    always_comb begin
        ctl_next   = ctl_reg;
        c_next     = c_reg;
        fe_next    = fe_reg;
        bri_next   = bri_reg;
        alpha_next = alpha_reg;
        if (in_ready) begin
            ctl_next.valid = in_ctl.valid;
        end
        if (in_ready && in_ctl.valid) begin
            ctl_next.model  = in_ctl.model;
            ctl_next.sector = in_ctl.sector;
            // chroma stays below one since k is at most one and saturation is below one
            c_next          = prod[2*N-1:N];
            bri_next        = in_bri;
            alpha_next      = in_alpha;
            if (in_ctl.sector[0]) begin
                fe_next = {1'b1, {N{1'b0}}} - {1'b0, in_f};
            end else begin
                fe_next = {1'b0, in_f};
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_next;
        end
        c_reg     <= c_next;
        fe_reg    <= fe_next;
        bri_reg   <= bri_next;
        alpha_reg <= alpha_next;
    end

    assign out_ctl   = ctl_reg;
    assign out_c     = c_reg;
    assign out_fe    = fe_reg;
    assign out_bri   = bri_reg;
    assign out_alpha = alpha_reg;

endmodule

/* src/hsv2rgb_blend.sv */
module hsv2rgb_blend #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hsv2rgb_pkg::stage_ctl_t       in_ctl,
    output logic                          in_ready,
    input  logic [CHANNEL_BITS-1:0]       in_c,
    input  logic [CHANNEL_BITS:0]         in_fe,
    input  logic [CHANNEL_BITS-1:0]       in_bri,
    input  logic [CHANNEL_BITS-1:0]       in_alpha,
    output hsv2rgb_pkg::stage_ctl_t       out_ctl,
    input  logic                          out_ready,
    output logic [CHANNEL_BITS-1:0]       out_c,
    output logic [CHANNEL_BITS-1:0]       out_x,
    output logic [CHANNEL_BITS-1:0]       out_m,
    output logic [CHANNEL_BITS-1:0]       out_alpha
);

    localparam int N = CHANNEL_BITS;

    hsv2rgb_pkg::stage_ctl_t ctl_reg, ctl_next;
    logic [N-1:0] c_reg, c_next;
    logic [N-1:0] x_reg, x_next;
    logic [N-1:0] m_reg, m_next;
    logic [N-1:0] alpha_reg, alpha_next;
    logic [2*N:0] xprod;
    logic [N:0]   c_round;

    assign in_ready = !ctl_reg.valid || out_ready;
    assign xprod    = (2*N+1)'(in_c) * (2*N+1)'(in_fe);
    assign c_round  = {1'b0, in_c} + (N+1)'(1);

    always_comb begin
        ctl_next   = ctl_reg;
        c_next     = c_reg;
        x_next     = x_reg;
        m_next     = m_reg;
        alpha_next = alpha_reg;
        if (in_ready) begin
            ctl_next.valid = in_ctl.valid;
        end
        if (in_ready && in_ctl.valid) begin
            ctl_next.model  = in_ctl.model;
            ctl_next.sector = in_ctl.sector;
            c_next          = in_c;
            x_next          = xprod[2*N-1:N];
            alpha_next      = in_alpha;
            if (in_ctl.model == hsv2rgb_pkg::MODEL_HSL) begin
                m_next = in_bri - c_round[N:1];
            end else begin
                m_next = in_bri - in_c;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ctl_reg <= '0;
        end else begin
            ctl_reg <= ctl_next;
        end
        c_reg     <= c_next;
        x_reg     <= x_next;
        m_reg     <= m_next;
        alpha_reg <= alpha_next;
    end

    assign out_ctl   = ctl_reg;
    assign out_c     = c_reg;
    assign out_x     = x_reg;
    assign out_m     = m_reg;
    assign out_alpha = alpha_reg;

endmodule

/* src/hsv2rgb_mix.sv */
module hsv2rgb_mix #(
    parameter int CHANNEL_BITS = 16
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  hsv2rgb_pkg::stage_ctl_t       in_ctl,
    output logic                          in_ready,
    input  logic [CHANNEL_BITS-1:0]       in_c,
    input  logic [CHANNEL_BITS-1:0]       in_x,
    input  logic [CHANNEL_BITS-1:0]       in_m,
    input  logic [CHANNEL_BITS-1:0]       in_alpha,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [CHANNEL_BITS-1:0]       out_red,
    output logic [CHANNEL_BITS-1:0]       out_green,
    output logic [CHANNEL_BITS-1:0]       out_blue,
    output logic [CHANNEL_BITS-1:0]       out_alpha
);

    localparam int N = CHANNEL_BITS;

    logic         valid_reg, valid_next;
    logic [N-1:0] red_reg, red_next;
    logic [N-1:0] green_reg, green_next;
    logic [N-1:0] blue_reg, blue_next;
    logic [N-1:0] alpha_reg, alpha_next;
    logic [N-1:0] r_sel, g_sel, b_sel;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        unique case (in_ctl.sector)
            hsv2rgb_pkg::SECTOR_0: begin
                r_sel = in_c;   g_sel = in_x;   b_sel = '0;
            end
            hsv2rgb_pkg::SECTOR_1: begin
                r_sel = in_x;   g_sel = in_c;   b_sel = '0;
            end
            hsv2rgb_pkg::SECTOR_2: begin
                r_sel = '0;     g_sel = in_c;   b_sel = in_x;
            end
            hsv2rgb_pkg::SECTOR_3: begin
                r_sel = '0;     g_sel = in_x;   b_sel = in_c;
            end
            hsv2rgb_pkg::SECTOR_4: begin
                r_sel = in_x;   g_sel = '0;     b_sel = in_c;
            end
            default: begin
                r_sel = in_c;   g_sel = '0;     b_sel = in_x;
            end
        endcase
    end

    always_comb begin
        valid_next = valid_reg;
        red_next   = red_reg;
        green_next = green_reg;
        blue_next  = blue_reg;
        alpha_next = alpha_reg;
        if (in_ready) begin
            valid_next = in_ctl.valid;
        end
        if (in_ready && in_ctl.valid) begin
            red_next   = r_sel + in_m;
            green_next = g_sel + in_m;
            blue_next  = b_sel + in_m;
            alpha_next = in_alpha;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        red_reg   <= red_next;
        green_reg <= green_next;
        blue_reg  <= blue_next;
        alpha_reg <= alpha_next;
    end

    assign out_valid = valid_reg;
    assign out_red   = red_reg;
    assign out_green = green_reg;
    assign out_blue  = blue_reg;
    assign out_alpha = alpha_reg;

endmodule
